// File: design/grmm_pkg.sv
// Shared types and codes for the gimbal relative mecanum mixer.
// No dependencies; used by every module under design/.
package grmm_pkg;

  // Spin selection carried in the input tuser field
  typedef enum logic [1:0] {
    MODE_NO_FOLLOW = 2'd0,
    MODE_FOLLOW    = 2'd1,
    MODE_ROTATE    = 2'd2,
    MODE_SPIN      = 2'd3
  } mode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ANGLE_OFFSET = 2'd0,
    CFG_WHEEL_GAIN   = 2'd1,
    CFG_ROTATE_SPEED = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned GainW    = 24;

  // Fields that ride along with the angle path
  typedef struct packed {
    logic signed [15:0] cvx;
    logic signed [15:0] cvy;
    logic signed [15:0] vz;
    logic signed [16:0] heading;
  } side_t;

  // Quarter-wave arguments for lane 0 (sine) and lane 1 (cosine)
  typedef struct packed {
    logic [1:0][12:0] rr;
    logic [1:0]       neg;
    side_t            side;
  } hd_t;

  typedef struct packed {
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
    side_t              side;
  } sc_t;

  // Wheel order: right front, left front, left rear, right rear
  typedef struct packed {
    logic [16:0]      heading;
    logic [3:0][31:0] wheel;
  } wh_t;

endpackage

// File: design/grmm_heading.sv
// Heading wrap, spin select and quadrant split (three stages).
// Depends on grmm_pkg.
module grmm_heading (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic signed [15:0]    cvx_i,
  input  logic signed [15:0]    cvy_i,
  input  logic signed [15:0]    rvz_i,
  input  grmm_pkg::mode_e       mode_i,
  input  logic signed [15:0]    yaw_i,
  input  logic signed [15:0]    angle_offset_i,
  input  logic signed [15:0]    rotate_speed_i,
  output logic                  vld_o,
  output grmm_pkg::hd_t         hd_o
);

  localparam logic signed [16:0] HalfTurnNeg = -17'sd11520;
  localparam logic signed [16:0] Turn        = 17'sd23040;
  localparam logic signed [17:0] ThreeTurns  = 18'sd69120;
  localparam logic [21:0]        Recip45     = 22'd1457;   // 2^16 / 45, rounded up
  localparam logic [17:0]        Quarter18   = 18'd5760;
  localparam logic [12:0]        Quarter     = 13'd5760;

  logic [2:0] vld_q;

  // stage 1
  logic signed [16:0] h0, h_d;
  logic signed [15:0] vz_d;
  grmm_pkg::side_t    s1_q;

  // stage 2
  logic [17:0]     m_d, m_q;
  logic [21:0]     qp;
  logic [4:0]      q_d, q_q;
  grmm_pkg::side_t s2_q;

  // stage 3
  logic [12:0]     rem;
  logic [1:0]      quad;
  grmm_pkg::hd_t   hd_d, hd_q;

  always_comb begin
    h0  = {yaw_i[15], yaw_i} - {angle_offset_i[15], angle_offset_i};
    h_d = (h0 < HalfTurnNeg) ? h0 + Turn : h0;
    case (mode_i)
      grmm_pkg::MODE_ROTATE: vz_d = rotate_speed_i;
      grmm_pkg::MODE_SPIN:   vz_d = rvz_i;
      default:               vz_d = '0;
    endcase
  end

  // m = h + 3 turns is positive; quotient by 5760 = (m >> 7) / 45
  always_comb begin
    m_d = 18'($signed({s1_q.heading[16], s1_q.heading}) + ThreeTurns);
    qp  = 22'(m_d[17:7]) * Recip45;
    q_d = qp[20:16];
  end

  always_comb begin
    rem  = 13'(m_q - 18'(18'(q_q) * Quarter18));
    quad = q_q[1:0];
    hd_d.side = s2_q;
    for (int l = 0; l < 2; l++) begin
      logic [1:0] ql;
      ql = quad + 2'(l);
      hd_d.rr[l]  = ql[0] ? Quarter - rem : rem;
      hd_d.neg[l] = ql[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q.cvx     <= cvx_i;
      s1_q.cvy     <= cvy_i;
      s1_q.vz      <= vz_d;
      s1_q.heading <= h_d;
      m_q          <= m_d;
      q_q          <= q_d;
      s2_q         <= s1_q;
      hd_q         <= hd_d;
    end
  end

  assign vld_o = vld_q[2];
  assign hd_o  = hd_q;

endmodule

// File: design/grmm_sincos.sv
// Q1.15 sine and cosine by a pipelined quarter-wave Taylor series,
// two lanes side by side, four stages per series term. Depends on grmm_pkg.
module grmm_sincos (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  grmm_pkg::hd_t hd_i,
  output logic          vld_o,
  output grmm_pkg::sc_t sc_o
);

  localparam int unsigned Terms  = 5;
  localparam int unsigned Nst    = Terms * 4;
  localparam logic [31:0] RadQ30 = 32'd292817;

  logic [Nst+2:0]     vld_q;
  grmm_pkg::side_t    side_q [Nst+3];
  logic [1:0]         neg_q  [Nst+3];
  logic [30:0]        x_q    [Nst][2];
  logic [31:0]        term_q [Nst+1][2];
  logic signed [33:0] sum_q  [Nst+1][2];
  logic [62:0]        prod_q [Nst+1][2];
  logic [14:0]        mag_q  [2];
  logic signed [15:0] val_q  [2];

  logic [30:0]        x_d   [2];
  logic [14:0]        mag_d [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      x_d[l] = 31'(32'(hd_i.rr[l]) * RadQ30);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Nst+1:0], vld_i};
    end
  end

  // entry stage and pass-through fields
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= hd_i.side;
      neg_q[0]  <= hd_i.neg;
      for (int l = 0; l < 2; l++) begin
        x_q[0][l]    <= x_d[l];
        term_q[0][l] <= 32'(x_d[l]);
        sum_q[0][l]  <= $signed(34'(x_d[l]));
        prod_q[0][l] <= '0;
      end
      for (int j = 1; j < Nst + 3; j++) begin
        side_q[j] <= side_q[j-1];
        neg_q[j]  <= neg_q[j-1];
      end
      for (int j = 1; j < Nst; j++) begin
        x_q[j] <= x_q[j-1];
      end
    end
  end

  // term k: two products by x, divide by (2k)(2k+1), accumulate
  for (genvar g = 0; g < Terms; g++) begin : g_term
    localparam int unsigned B     = 4 * g;
    localparam int unsigned DivI  = (2 * g + 2) * (2 * g + 3);
    localparam logic [31:0] Div   = 32'(DivI);
    localparam logic [29:0] Recip = 30'((64'd1 << 32) / DivI);

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [29:0]        q0;
      logic [31:0]        rem;
      logic [31:0]        qn;
      logic signed [33:0] snew;

      always_comb begin
        q0   = prod_q[B+3][l][61:32];
        rem  = term_q[B+3][l] - 32'(32'(q0) * Div);
        qn   = 32'(q0) + 32'(rem >= Div);
        snew = (g % 2 == 0) ? sum_q[B+3][l] - $signed(34'(qn))
                            : sum_q[B+3][l] + $signed(34'(qn));
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_q[B+1][l] <= 63'(term_q[B][l]) * 63'(x_q[B][l]);
          term_q[B+1][l] <= term_q[B][l];
          sum_q[B+1][l]  <= sum_q[B][l];

          prod_q[B+2][l] <= 63'(prod_q[B+1][l][61:30]) * 63'(x_q[B+1][l]);
          term_q[B+2][l] <= term_q[B+1][l];
          sum_q[B+2][l]  <= sum_q[B+1][l];

          prod_q[B+3][l] <= 63'(prod_q[B+2][l][61:30]) * 63'(Recip);
          term_q[B+3][l] <= prod_q[B+2][l][61:30];
          sum_q[B+3][l]  <= sum_q[B+2][l];

          prod_q[B+4][l] <= prod_q[B+3][l];
          term_q[B+4][l] <= qn;
          sum_q[B+4][l]  <= snew;
        end
      end
    end
  end

  // clamp at zero, round half up to Q1.15, clamp at full scale
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [32:0] pos;
      logic [33:0] rsum;
      pos      = sum_q[Nst][l][33] ? '0 : sum_q[Nst][l][32:0];
      rsum     = 34'(pos) + 34'd16384;
      mag_d[l] = (|rsum[33:30]) ? 15'h7fff : rsum[29:15];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        mag_q[l] <= mag_d[l];
        val_q[l] <= neg_q[Nst+1][l] ? -$signed({1'b0, mag_q[l]})
                                    : $signed({1'b0, mag_q[l]});
      end
    end
  end

  assign vld_o      = vld_q[Nst+2];
  assign sc_o.sin_v = val_q[0];
  assign sc_o.cos_v = val_q[1];
  assign sc_o.side  = side_q[Nst+2];

endmodule

// File: design/grmm_mixer.sv
// Frame rotation, mecanum mix, gain, rounding and saturation (six stages).
// Depends on grmm_pkg.
module grmm_mixer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  grmm_pkg::sc_t               sc_i,
  input  logic [grmm_pkg::GainW-1:0]  gain_i,
  output logic                        vld_o,
  output grmm_pkg::wh_t               wh_o
);

  localparam logic signed [59:0] RoundBias = 60'sd67108864;  // 2^26

  logic [5:0] vld_q;

  // stage 1: the four rotation products
  logic signed [31:0] pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [15:0] vz1_q;
  logic [16:0]        h1_q;

  // stage 2: chassis-frame velocities
  logic signed [32:0] vx_q, vy_q, vz_q;
  logic [16:0]        h2_q;

  // stage 3: wheel sums
  logic signed [34:0] ws_q [4];
  logic [16:0]        h3_q;

  // stage 4: gain split in two partial products
  logic signed [42:0] phi_q [4];
  logic [40:0]        plo_q [4];
  logic [16:0]        h4_q;

  // stage 5: negate and add rounding bias
  logic signed [59:0] rnd_q [4];
  logic [16:0]        h5_q;

  // stage 6: shift and saturate
  grmm_pkg::wh_t      wh_d, wh_q;

  always_comb begin
    wh_d.heading = h5_q;
    for (int w = 0; w < 4; w++) begin
      logic signed [32:0] ys;
      ys = rnd_q[w][59:27];
      if (ys[32] == ys[31]) begin
        wh_d.wheel[w] = ys[31:0];
      end else if (ys[32]) begin
        wh_d.wheel[w] = 32'h8000_0000;
      end else begin
        wh_d.wheel[w] = 32'h7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxc_q <= sc_i.side.cvx * sc_i.cos_v;
      pys_q <= sc_i.side.cvy * sc_i.sin_v;
      pxs_q <= sc_i.side.cvx * sc_i.sin_v;
      pyc_q <= sc_i.side.cvy * sc_i.cos_v;
      vz1_q <= sc_i.side.vz;
      h1_q  <= sc_i.side.heading;

      vx_q <= -(33'(pxc_q) + 33'(pys_q));
      vy_q <= 33'(pxs_q) - 33'(pyc_q);
      vz_q <= 33'(vz1_q) <<< 15;
      h2_q <= h1_q;

      ws_q[0] <= -35'(vx_q) + 35'(vy_q) + 35'(vz_q);
      ws_q[1] <=  35'(vx_q) + 35'(vy_q) + 35'(vz_q);
      ws_q[2] <=  35'(vx_q) - 35'(vy_q) + 35'(vz_q);
      ws_q[3] <= -35'(vx_q) - 35'(vy_q) + 35'(vz_q);
      h3_q    <= h2_q;

      for (int w = 0; w < 4; w++) begin
        phi_q[w] <= 43'($signed(ws_q[w][34:17])) * 43'($signed({1'b0, gain_i}));
        plo_q[w] <= 41'(ws_q[w][16:0]) * 41'(gain_i);
        rnd_q[w] <= RoundBias - ((60'(phi_q[w]) <<< 17) + $signed({19'b0, plo_q[w]}));
      end
      h4_q <= h3_q;
      h5_q <= h4_q;

      wh_q <= wh_d;
    end
  end

  assign vld_o = vld_q[5];
  assign wh_o  = wh_q;

endmodule

// File: design/gimbal_relative_mecanum_mixer.sv
// Gimbal relative mecanum mixer: 33 register stages (heading 3, sine/cosine 23,
// mixer 6, output 1). Throughput one transaction per cycle while the skid slot
// is empty (a full skid slot stalls every stage): every stage is a plain register
// with no multi-cycle unit; the sine/cosine path (five Taylor terms of four stages
// each, every multiply registered) sets most of the latency. Reset (rst_ni low,
// asynchronous) clears all valid bits and loads offset 0, gain 4096, rotate 24.
module gimbal_relative_mecanum_mixer (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [grmm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [grmm_pkg::CfgDataW-1:0]  cfg_data_i,

  // command stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] command_vx, [31:16] command_vy, [47:32] request_vz, [63:48] yaw_angle
  input  logic [63:0]                    s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]                     s_axis_tuser,

  // wheel setpoint stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] wheel_right_front, [63:32] wheel_left_front, [95:64] wheel_left_rear,
  // [127:96] wheel_right_rear, [144:128] heading_offset, [151:145] zero
  output logic [151:0]                   m_axis_tdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user writes them only while the pipe is empty,
  // unenforced by the block. Stages read them live; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  logic signed [15:0]           angle_offset_q;
  logic [grmm_pkg::GainW-1:0]   wheel_gain_q;
  logic signed [15:0]           rotate_speed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_offset_q <= '0;
      wheel_gain_q   <= grmm_pkg::GainW'(4096);
      rotate_speed_q <= 16'sd24;
    end else if (cfg_valid_i) begin
      case (grmm_pkg::cfg_idx_e'(cfg_index_i))
        grmm_pkg::CFG_ANGLE_OFFSET: angle_offset_q <= cfg_data_i[15:0];
        grmm_pkg::CFG_WHEEL_GAIN:   wheel_gain_q   <= cfg_data_i[grmm_pkg::GainW-1:0];
        grmm_pkg::CFG_ROTATE_SPEED: rotate_speed_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe advance. Every stage moves together while the skid slot is empty.
  // The output register plus one skid slot absorb the item that is already
  // leaving the last stage when m_axis_tready drops, so a stall loses nothing
  // and tready on the input side comes straight from a flop.
  // ---------------------------------------------------------------------------
  logic pipe_en;
  logic skid_vld_q, skid_vld_d;
  logic out_vld_q, out_vld_d;
  grmm_pkg::wh_t skid_q, skid_d, out_q, out_d;

  assign pipe_en       = ~skid_vld_q;
  assign s_axis_tready = pipe_en;

  // stage handoffs
  logic          hd_vld, sc_vld, wh_vld;
  grmm_pkg::hd_t hd;
  grmm_pkg::sc_t sc;
  grmm_pkg::wh_t wh;

  // heading wrap, spin pick, quadrant split
  grmm_heading u_heading (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (pipe_en),
    .vld_i          (s_axis_tvalid),
    .cvx_i          (s_axis_tdata[15:0]),
    .cvy_i          (s_axis_tdata[31:16]),
    .rvz_i          (s_axis_tdata[47:32]),
    .mode_i         (grmm_pkg::mode_e'(s_axis_tuser)),
    .yaw_i          (s_axis_tdata[63:48]),
    .angle_offset_i (angle_offset_q),
    .rotate_speed_i (rotate_speed_q),
    .vld_o          (hd_vld),
    .hd_o           (hd)
  );

  // sine in lane 0, cosine in lane 1
  grmm_sincos u_sincos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (hd_vld),
    .hd_i   (hd),
    .vld_o  (sc_vld),
    .sc_o   (sc)
  );

  // rotate into chassis frame, mix, gain, saturate
  grmm_mixer u_mixer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (sc_vld),
    .sc_i   (sc),
    .gain_i (wheel_gain_q),
    .vld_o  (wh_vld),
    .wh_o   (wh)
  );

  // ---------------------------------------------------------------------------
  // Output register and skid slot.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (pipe_en) begin
      if (wh_vld) begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_d     = wh;
        end else begin
          skid_vld_d = 1'b1;
          skid_d     = wh;
        end
      end else if (m_axis_tready) begin
        out_vld_d = 1'b0;
      end
    end else if (m_axis_tready) begin
      // skid is full, so out holds a result too
      out_d      = skid_q;
      skid_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_q.heading, out_q.wheel[3], out_q.wheel[2],
                          out_q.wheel[1], out_q.wheel[0]};

endmodule
